>>> hw/rtl/spm_pkg.sv
package spm_pkg;

    // default sizes
    localparam int MAX_TERMS_DEF  = 8;
    localparam int PROD_TERMS_DEF = 64;

    // field widths
    localparam int COEF_W = 32;
    localparam int EXP_W  = 10;
    localparam int PEXP_W = 11;

    // stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TUSER_W = 2;

    // exponent-indexed accumulation map: valid bit over coefficient
    localparam int MAP_DEPTH = 2048;
    localparam int MAP_W     = COEF_W + 1;

    // request codes
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_RUN    = 2'd2;

    localparam logic signed [COEF_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [COEF_W-1:0] Q_MIN = 32'sh8000_0000;

endpackage

>>> hw/rtl/sparse_polynomial_multiply.sv
// channel | dir | tdata (low bit up)                  | tuser                      | tlast
// s_      | in  | term_coef[31:0], term_exp[41:32]    | req_type[1:0]              | -
// m_      | out | out_coef[31:0], out_exp[42:32]      | is_zero_poly[0], overflow[1] | is_last
//
// loads are taken in idle; a run steps each a*b term pair through the multiply, shift and
// accumulate states of the shared path, then a read and a check state per map address while
// sweeping the 2048-entry exponent map (skipped when no entry was made), then a finish state
// after reset a clearing pass writes every entry of the exponent map, s_tready low
// a stalled m_ side holds the sweep in place; loads are taken while a result waits
module sparse_polynomial_multiply #(
    parameter int MAX_TERMS  = spm_pkg::MAX_TERMS_DEF,
    parameter int PROD_TERMS = spm_pkg::PROD_TERMS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spm_pkg::S_TDATA_W-1:0] s_tdata,   // term_coef, term_exp
    input  logic [spm_pkg::S_TUSER_W-1:0] s_tuser,   // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [spm_pkg::M_TDATA_W-1:0] m_tdata,   // out_coef, out_exp
    output logic [spm_pkg::M_TUSER_W-1:0] m_tuser,   // is_zero_poly, overflow
    output logic                          m_tlast    // is_last
);

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int NW = $clog2(PROD_TERMS + 1);
    localparam int AW = $clog2(spm_pkg::MAP_DEPTH);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SHF  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_SRD  = 3'd5;
    localparam logic [2:0] ST_SCHK = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    // operand stores
    logic [spm_pkg::COEF_W-1:0] a_coef_reg [MAX_TERMS];
    logic [spm_pkg::EXP_W-1:0]  a_exp_reg  [MAX_TERMS];
    logic [spm_pkg::COEF_W-1:0] b_coef_reg [MAX_TERMS];
    logic [spm_pkg::EXP_W-1:0]  b_exp_reg  [MAX_TERMS];
    logic a_we, b_we;

    // exponent map memory
    logic [spm_pkg::MAP_W-1:0] map_mem [spm_pkg::MAP_DEPTH];
    logic [spm_pkg::MAP_W-1:0] map_rd_reg;
    logic                      mem_re, mem_we;
    logic [AW-1:0]             mem_ra, mem_wa;
    logic [spm_pkg::MAP_W-1:0] mem_wd;

    // control
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] a_count_reg, a_count_next, b_count_reg, b_count_next;
    logic          drop_reg, drop_next;
    logic          ovf_reg, ovf_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next;
    logic [NW-1:0] n_reg, n_next;
    logic [AW-1:0] swp_reg, swp_next;
    logic          pend_v_reg, pend_v_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // payload
    logic signed [63:0]                prod_reg, prod_next;
    logic [spm_pkg::PEXP_W-1:0]        e_reg, e_next;
    logic signed [spm_pkg::COEF_W-1:0] c_reg, c_next;
    logic [spm_pkg::COEF_W-1:0]        pend_coef_reg, pend_coef_next;
    logic [spm_pkg::PEXP_W-1:0]        pend_exp_reg, pend_exp_next;
    logic [spm_pkg::COEF_W-1:0]        m_coef_reg, m_coef_next;
    logic [spm_pkg::PEXP_W-1:0]        m_exp_reg, m_exp_next;
    logic                              m_last_reg, m_last_next;
    logic                              m_zero_reg, m_zero_next;
    logic                              m_ovf_reg, m_ovf_next;

    // input field views
    logic signed [spm_pkg::COEF_W-1:0] in_coef;
    logic [spm_pkg::EXP_W-1:0]         in_exp;
    assign in_coef = s_tdata[spm_pkg::COEF_W-1:0];
    assign in_exp  = s_tdata[spm_pkg::COEF_W +: spm_pkg::EXP_W];

    logic        out_free;
    logic [47:0] shifted;
    logic        prod_sat;
    logic signed [spm_pkg::COEF_W:0] sum;
    logic        sum_sat;
    logic        hit, adv;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        a_count_next   = a_count_reg;
        b_count_next   = b_count_reg;
        drop_next      = drop_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        swp_next       = swp_reg;
        pend_v_next    = pend_v_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        prod_next      = prod_reg;
        e_next         = e_reg;
        c_next         = c_reg;
        pend_coef_next = pend_coef_reg;
        pend_exp_next  = pend_exp_reg;
        m_coef_next    = m_coef_reg;
        m_exp_next     = m_exp_reg;
        m_last_next    = m_last_reg;
        m_zero_next    = m_zero_reg;
        m_ovf_next     = m_ovf_reg;
        a_we           = 1'b0;
        b_we           = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_ra         = swp_reg;
        mem_wa         = swp_reg;
        mem_wd         = '0;
        s_tready       = 1'b0;
        shifted        = prod_reg[63:16];
        prod_sat       = 1'b0;
        sum            = '0;
        sum_sat        = 1'b0;
        hit            = 1'b0;
        adv            = 1'b1;

        case (state_reg)
            ST_CLR: begin
                mem_we = 1'b1;
                if (swp_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    swp_next = swp_reg - 1'b1;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_tuser)
                        spm_pkg::REQ_LOAD_A: begin
                            if (in_coef != 0) begin
                                if (a_count_reg == CW'(MAX_TERMS)) begin
                                    drop_next = 1'b1;
                                end else begin
                                    a_we         = 1'b1;
                                    a_count_next = a_count_reg + 1'b1;
                                end
                            end
                        end
                        spm_pkg::REQ_LOAD_B: begin
                            if (in_coef != 0) begin
                                if (b_count_reg == CW'(MAX_TERMS)) begin
                                    drop_next = 1'b1;
                                end else begin
                                    b_we         = 1'b1;
                                    b_count_next = b_count_reg + 1'b1;
                                end
                            end
                        end
                        spm_pkg::REQ_RUN: begin
                            ovf_next = drop_reg;
                            i_next   = '0;
                            j_next   = '0;
                            n_next   = '0;
                            if (a_count_reg == '0 || b_count_reg == '0) begin
                                state_next = ST_FIN;
                            end else begin
                                state_next = ST_MUL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MUL: begin
                prod_next = $signed(a_coef_reg[i_reg]) * $signed(b_coef_reg[j_reg]);
                e_next    = {1'b0, a_exp_reg[i_reg]} + {1'b0, b_exp_reg[j_reg]};
                mem_re    = 1'b1;
                mem_ra    = e_next;
                state_next = ST_SHF;
            end
            ST_SHF: begin
                // floor shift, then clamp to 32 bits
                prod_sat = (shifted[47:31] != {17{shifted[47]}});
                if (prod_sat) begin
                    c_next = shifted[47] ? spm_pkg::Q_MIN : spm_pkg::Q_MAX;
                end else begin
                    c_next = shifted[31:0];
                end
                ovf_next   = ovf_reg | prod_sat;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                mem_wa = e_reg;
                if (map_rd_reg[spm_pkg::COEF_W]) begin
                    sum = {map_rd_reg[spm_pkg::COEF_W-1], map_rd_reg[spm_pkg::COEF_W-1:0]}
                        + {c_reg[spm_pkg::COEF_W-1], c_reg};
                    sum_sat = sum[spm_pkg::COEF_W] != sum[spm_pkg::COEF_W-1];
                    mem_we  = 1'b1;
                    if (sum_sat) begin
                        mem_wd = {1'b1, (sum[spm_pkg::COEF_W] ? spm_pkg::Q_MIN
                                                              : spm_pkg::Q_MAX)};
                    end else begin
                        mem_wd = {1'b1, sum[spm_pkg::COEF_W-1:0]};
                    end
                    ovf_next = ovf_reg | sum_sat;
                end else if (c_reg != 0) begin
                    if (n_reg == NW'(PROD_TERMS)) begin
                        ovf_next = 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        mem_wd = {1'b1, c_reg};
                        n_next = n_reg + 1'b1;
                    end
                end
                // advance b, then a
                if (CW'(j_reg) + 1'b1 == b_count_reg) begin
                    j_next = '0;
                    if (CW'(i_reg) + 1'b1 == a_count_reg) begin
                        swp_next   = AW'(spm_pkg::MAP_DEPTH - 1);
                        state_next = (n_next == '0) ? ST_FIN : ST_SRD;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_SRD: begin
                // read and clear the same address
                mem_re     = 1'b1;
                mem_we     = 1'b1;
                state_next = ST_SCHK;
            end
            ST_SCHK: begin
                hit = map_rd_reg[spm_pkg::COEF_W] && (map_rd_reg[spm_pkg::COEF_W-1:0] != '0);
                if (hit) begin
                    if (!pend_v_reg) begin
                        pend_v_next    = 1'b1;
                        pend_coef_next = map_rd_reg[spm_pkg::COEF_W-1:0];
                        pend_exp_next  = swp_reg;
                    end else if (out_free) begin
                        m_tvalid_next  = 1'b1;
                        m_coef_next    = pend_coef_reg;
                        m_exp_next     = pend_exp_reg;
                        m_last_next    = 1'b0;
                        m_zero_next    = 1'b0;
                        m_ovf_next     = ovf_reg;
                        pend_coef_next = map_rd_reg[spm_pkg::COEF_W-1:0];
                        pend_exp_next  = swp_reg;
                    end else begin
                        adv = 1'b0;
                    end
                end
                if (adv) begin
                    if (swp_reg == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        swp_next   = swp_reg - 1'b1;
                        state_next = ST_SRD;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_last_next   = 1'b1;
                    m_ovf_next    = ovf_reg;
                    if (pend_v_reg) begin
                        m_coef_next = pend_coef_reg;
                        m_exp_next  = pend_exp_reg;
                        m_zero_next = 1'b0;
                    end else begin
                        m_coef_next = '0;
                        m_exp_next  = '0;
                        m_zero_next = 1'b1;
                    end
                    pend_v_next  = 1'b0;
                    a_count_next = '0;
                    b_count_next = '0;
                    drop_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            swp_reg      <= AW'(spm_pkg::MAP_DEPTH - 1);
            a_count_reg  <= '0;
            b_count_reg  <= '0;
            drop_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            n_reg        <= '0;
            pend_v_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            swp_reg      <= swp_next;
            a_count_reg  <= a_count_next;
            b_count_reg  <= b_count_next;
            drop_reg     <= drop_next;
            ovf_reg      <= ovf_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            n_reg        <= n_next;
            pend_v_reg   <= pend_v_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        prod_reg      <= prod_next;
        e_reg         <= e_next;
        c_reg         <= c_next;
        pend_coef_reg <= pend_coef_next;
        pend_exp_reg  <= pend_exp_next;
        m_coef_reg    <= m_coef_next;
        m_exp_reg     <= m_exp_next;
        m_last_reg    <= m_last_next;
        m_zero_reg    <= m_zero_next;
        m_ovf_reg     <= m_ovf_next;
        if (a_we) begin
            a_coef_reg[a_count_reg[IW-1:0]] <= in_coef;
            a_exp_reg[a_count_reg[IW-1:0]]  <= in_exp;
        end
        if (b_we) begin
            b_coef_reg[b_count_reg[IW-1:0]] <= in_coef;
            b_exp_reg[b_count_reg[IW-1:0]]  <= in_exp;
        end
    end

    // exponent map, read returns the old word on a same-address write
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            map_rd_reg <= map_mem[mem_ra];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(spm_pkg::M_TDATA_W - spm_pkg::COEF_W - spm_pkg::PEXP_W){1'b0}},
                       m_exp_reg, m_coef_reg};
    assign m_tuser  = {m_ovf_reg, m_zero_reg};
    assign m_tlast  = m_last_reg;

    // product entry count never passes capacity
    assert property (@(posedge aclk) disable iff (!aresetn) n_reg <= NW'(PROD_TERMS))
        else $error("product entry count over capacity");

    // operand counts never pass capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_count_reg <= CW'(MAX_TERMS) && b_count_reg <= CW'(MAX_TERMS))
        else $error("operand count over capacity");

    // a zero-polynomial result is always the last of its run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("zero product not marked last");

    // finishing with a free output slot presents the closing transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && out_free |=> m_tvalid && m_tlast && state_reg == ST_IDLE)
        else $error("run finished without last transfer");

    // no transfer is taken while the run is in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready)
        else $error("input taken while busy");

endmodule

>>> test/spm_checker.sv
`timescale 1ns / 1ps

module spm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          terms_pending,
    output int          runs_seen,
    output int          terms_seen
);

    typedef struct packed {
        logic signed [31:0] coef;
        logic [10:0]        pexp;
        logic               last;
        logic               zero_poly;
        logic               ovf;
    } prod_term_t;

    // local copy of the operand stores
    logic signed [31:0] a_coef [8];
    logic [9:0]         a_exp  [8];
    logic signed [31:0] b_coef [8];
    logic [9:0]         b_exp  [8];
    int                 a_cnt, b_cnt;
    bit                 dropped;

    prod_term_t product_q[$];

    function automatic logic signed [31:0] sat32(longint v, ref bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1;
            return spm_pkg::Q_MAX;
        end
        if (v < -64'sd2147483648) begin
            sat = 1;
            return spm_pkg::Q_MIN;
        end
        return v[31:0];
    endfunction

    // multiply out both operands, merge by exponent, drop zero sums, sort descending
    task automatic multiply_operands();
        logic signed [31:0] pc [64];
        logic [10:0]        pe [64];
        logic signed [31:0] c, tc;
        logic [10:0]        e, te;
        longint             p;
        int                 n, m, k;
        bit                 ovf, found;
        prod_term_t         t;
        ovf = dropped;
        n = 0;
        for (int i = 0; i < a_cnt; i++) begin
            for (int j = 0; j < b_cnt; j++) begin
                e = {1'b0, a_exp[i]} + {1'b0, b_exp[j]};
                p = longint'(a_coef[i]) * longint'(b_coef[j]);
                c = sat32(p >>> 16, ovf);
                found = 0;
                for (k = 0; k < n; k++) begin
                    if (pe[k] == e) begin
                        pc[k] = sat32(longint'(pc[k]) + longint'(c), ovf);
                        found = 1;
                        break;
                    end
                end
                if (!found && c != 0) begin
                    if (n < 64) begin
                        pc[n] = c;
                        pe[n] = e;
                        n++;
                    end else begin
                        ovf = 1;
                    end
                end
            end
        end
        m = 0;
        for (int i = 0; i < n; i++) begin
            if (pc[i] != 0) begin
                pc[m] = pc[i];
                pe[m] = pe[i];
                m++;
            end
        end
        n = m;
        for (int i = 0; i < n; i++) begin
            m = i;
            for (int j = i + 1; j < n; j++)
                if (pe[j] > pe[m]) m = j;
            tc = pc[i]; te = pe[i];
            pc[i] = pc[m]; pe[i] = pe[m];
            pc[m] = tc; pe[m] = te;
        end
        if (n == 0) begin
            t = '{coef: 0, pexp: 0, last: 1, zero_poly: 1, ovf: ovf};
            product_q.push_back(t);
        end else begin
            for (int i = 0; i < n; i++) begin
                t = '{coef: pc[i], pexp: pe[i], last: (i == n - 1), zero_poly: 0, ovf: ovf};
                product_q.push_back(t);
            end
        end
        a_cnt = 0;
        b_cnt = 0;
        dropped = 0;
    endtask

    always @(posedge aclk) begin
        prod_term_t exp_t, got;
        if (!aresetn) begin
            a_cnt   = 0;
            b_cnt   = 0;
            dropped = 0;
            product_q.delete();
            fail_count <= 0;
            runs_seen  <= 0;
            terms_seen <= 0;
        end else begin
            // result side first: a run accepted this edge cannot produce a result at it
            if (m_tvalid && m_tready) begin
                terms_seen <= terms_seen + 1;
                got = '{coef: m_tdata[31:0], pexp: m_tdata[42:32], last: m_tlast,
                        zero_poly: m_tuser[0], ovf: m_tuser[1]};
                if (product_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transfer: coef %h exp %0d", got.coef,
                                 got.pexp);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_t = product_q.pop_front();
                    if (got !== exp_t) begin
                        if (fail_count < 10)
                            $display({"mismatch: exp coef %h exp %0d last %b zp %b ovf %b",
                                      " / got coef %h exp %0d last %b zp %b ovf %b"},
                                     exp_t.coef, exp_t.pexp, exp_t.last, exp_t.zero_poly,
                                     exp_t.ovf, got.coef, got.pexp, got.last,
                                     got.zero_poly, got.ovf);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    spm_pkg::REQ_LOAD_A, spm_pkg::REQ_LOAD_B: begin
                        if (s_tdata[31:0] != 0) begin
                            if (s_tuser == spm_pkg::REQ_LOAD_A && a_cnt < 8) begin
                                a_coef[a_cnt] = s_tdata[31:0];
                                a_exp[a_cnt]  = s_tdata[41:32];
                                a_cnt++;
                            end else if (s_tuser == spm_pkg::REQ_LOAD_B && b_cnt < 8) begin
                                b_coef[b_cnt] = s_tdata[31:0];
                                b_exp[b_cnt]  = s_tdata[41:32];
                                b_cnt++;
                            end else begin
                                dropped = 1;
                            end
                        end
                    end
                    spm_pkg::REQ_RUN: begin
                        multiply_operands();
                        runs_seen <= runs_seen + 1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign terms_pending = product_q.size();

endmodule

>>> test/tb_sparse_polynomial_multiply.sv
`timescale 1ns / 1ps

module tb_sparse_polynomial_multiply;

    localparam int WATCHDOG_LIMIT = 40000;   // clearing pass plus a full run with stalls, many times over

    // request code with no function
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // term_coef[31:0], term_exp[41:32], zeros above
    logic [1:0]  s_tuser;    // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // out_coef[31:0], out_exp[42:32], zeros above
    logic [1:0]  m_tuser;    // is_zero_poly, overflow
    logic        m_tlast;    // is_last

    int fail_count, terms_pending, runs_seen, terms_seen;
    int send_idle_pct, recv_idle_pct;
    int item_count;
    int quiet_cycles;

    sparse_polynomial_multiply dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    spm_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .fail_count(fail_count), .terms_pending(terms_pending),
        .runs_seen(runs_seen), .terms_seen(terms_seen)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // receiver backpressure, changed on the falling edge
    initial m_tready = 0;
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog: cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d terms outstanding", terms_pending);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // one transfer on the input channel, then maybe a random gap
    task automatic send_item(logic [1:0] req, logic signed [31:0] coef, logic [9:0] ex);
        s_tvalid = 1;
        s_tuser  = req;
        s_tdata  = {6'd0, ex, coef};
        do @(posedge aclk); while (!s_tready);
        item_count++;
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    function automatic logic signed [31:0] pick_coef();
        case ($urandom_range(9))
            0:       return $urandom;                               // full range
            1:       return $urandom_range(1) ? spm_pkg::Q_MAX : spm_pkg::Q_MIN;
            2:       return $urandom_range(1) ? 32'sd1 : -32'sd1;     // tiny, floors toward zero or -1
            3:       return 0;                                       // ignored on load
            default: return ($urandom_range(1) ? 1 : -1) * int'($urandom_range(1, 32'h0008_0000));
        endcase
    endfunction

    // one random multiply: loads of A and B, at times an unused request, then a run
    task automatic random_product();
        int na, nb, span;
        na   = $urandom_range(9);
        nb   = $urandom_range(9);
        span = $urandom_range(1) ? 7 : 1023;   // narrow spans make exponents collide
        for (int i = 0; i < na; i++)
            send_item(spm_pkg::REQ_LOAD_A, pick_coef(), 10'($urandom_range(span)));
        for (int i = 0; i < nb; i++)
            send_item(spm_pkg::REQ_LOAD_B, pick_coef(), 10'($urandom_range(span)));
        if ($urandom_range(9) == 0) send_item(REQ_UNUSED, $urandom, 10'($urandom));
        send_item(spm_pkg::REQ_RUN, $urandom, 10'($urandom));
    endtask

    initial begin
        aresetn  = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tuser  = spm_pkg::REQ_LOAD_A;
        item_count    = 0;
        send_idle_pct = 35;
        recv_idle_pct = 72;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: empty product, extremes with saturation, ignored terms, cancellation
        send_item(spm_pkg::REQ_RUN, 0, '0);
        send_item(spm_pkg::REQ_LOAD_A, spm_pkg::Q_MAX, 10'd1023);
        send_item(spm_pkg::REQ_LOAD_A, spm_pkg::Q_MIN, 10'd0);
        send_item(spm_pkg::REQ_LOAD_A, 0, 10'd5);
        send_item(spm_pkg::REQ_LOAD_B, spm_pkg::Q_MIN, 10'd1023);
        send_item(spm_pkg::REQ_LOAD_B, -32'sd1, 10'd512);
        send_item(REQ_UNUSED, 32'sh1234_5678, 10'd3);
        send_item(spm_pkg::REQ_RUN, 0, '0);
        // x + 1 times x - 1 cancels the middle term
        send_item(spm_pkg::REQ_LOAD_A, 32'sh0001_0000, 10'd1);
        send_item(spm_pkg::REQ_LOAD_A, 32'sh0001_0000, 10'd0);
        send_item(spm_pkg::REQ_LOAD_B, 32'sh0001_0000, 10'd1);
        send_item(spm_pkg::REQ_LOAD_B, -32'sh0001_0000, 10'd0);
        send_item(spm_pkg::REQ_RUN, 0, '0);
        // product only of tiny values: positive floors to zero, run gives zero polynomial
        send_item(spm_pkg::REQ_LOAD_A, 32'sd1, 10'd3);
        send_item(spm_pkg::REQ_LOAD_B, 32'sd1, 10'd4);
        send_item(spm_pkg::REQ_RUN, 0, '0);

        // pause until the directed results have drained
        s_tvalid = 0;
        wait (terms_pending == 0);
        @(negedge aclk);

        // full store: 64 distinct exponents, and overflowing loads on both operands
        for (int i = 0; i < 9; i++)
            send_item(spm_pkg::REQ_LOAD_A, pick_coef() | 32'sd1, 10'(i * 8));
        for (int i = 0; i < 9; i++)
            send_item(spm_pkg::REQ_LOAD_B, 32'sh0002_0000, 10'(i));
        send_item(spm_pkg::REQ_RUN, 0, '0);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 35 : 0;
            while (item_count < 40 + 100 * (phase + 1)) random_product();
        end

        s_tvalid = 0;
        wait (terms_pending == 0);
        repeat (50) @(posedge aclk);

        $display("%0d input transfers, %0d runs, %0d product terms checked", item_count,
                 runs_seen, terms_seen);
        $display("covered empty products, saturation, dropped loads and a full product store");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/spm_pkg.sv
hw/rtl/sparse_polynomial_multiply.sv
test/spm_checker.sv
test/tb_sparse_polynomial_multiply.sv
